@@ rtl/mesh_packet_frame_parser_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the mesh packet frame parser
// Concurrent assertion shorthands, clocked on a rising edge and disabled
// while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef MESH_PACKET_FRAME_PARSER_MACROS_SVH
`define MESH_PACKET_FRAME_PARSER_MACROS_SVH

// same-cycle implication
`define MPFP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mpfp assertion failed");

// next-cycle implication
`define MPFP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mpfp assertion failed");

`endif

@@ rtl/mpfp_pkg.sv @@
// ----------------------------------------------------------------------------
// Mesh packet frame parser package
// Shared widths, codes, state structs and the CRC-16 byte update.
// ----------------------------------------------------------------------------
`default_nettype none

package mpfp_pkg;

  localparam int unsigned HeaderBytes = 32;
  localparam int unsigned CountW      = 17;
  localparam int unsigned OffsetW     = 16;
  localparam int unsigned ByteW       = 8;
  localparam int unsigned CrcW        = 16;
  localparam int unsigned NumNames    = 4;
  localparam int unsigned NumBounds   = 6;
  localparam int unsigned CfgIdxW     = 1;
  localparam int unsigned CfgDataW    = 16;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
  localparam logic [CrcW-1:0]   CrcInit  = 16'hFFFF;
  localparam logic [CrcW-1:0]   CrcPoly  = 16'h1021;
  localparam logic [CrcW-1:0]   CrcMsb   = 16'h8000;

  typedef enum logic [2:0] {
    SecHeader  = 3'd0,
    SecSource  = 3'd1,
    SecDest    = 3'd2,
    SecPrevHop = 3'd3,
    SecNextHop = 3'd4,
    SecPayload = 3'd5,
    SecCrc     = 3'd6,
    SecExcess  = 3'd7
  } section_e;

  typedef enum logic [2:0] {
    StatusOk      = 3'd0,
    StatusShort   = 3'd1,
    StatusMagic   = 3'd2,
    StatusVersion = 3'd3,
    StatusLength  = 3'd4,
    StatusCrc     = 3'd5
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMagicWord       = 1'b0,
    CfgProtocolVersion = 1'b1
  } cfg_idx_e;

  // frame state seen by the tagger; bound[k] is the end of section k+1
  typedef struct packed {
    logic [CountW-1:0]                count;
    logic [CrcW-1:0]                  crc_next;
    logic [ByteW-1:0]                 held1;
    logic                             magic_ok;
    logic                             version_ok;
    logic [NumBounds-1:0][CountW-1:0] bound;
  } frame_state_t;

  typedef struct packed {
    section_e             section;
    logic [OffsetW-1:0]   offset;
    status_e              status;
  } tag_t;

  function automatic logic [CrcW-1:0] crc_feed(input logic [CrcW-1:0] crc,
                                               input logic [ByteW-1:0] b);
    logic [CrcW-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CrcMsb) != '0) begin
        c = (c << 1) ^ CrcPoly;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/mpfp_if.sv @@
// ----------------------------------------------------------------------------
// Mesh packet frame parser channels
// Valid/ready channels for received bytes and for tagged results.
// ----------------------------------------------------------------------------
`default_nettype none

interface mpfp_in_if;
  logic                            valid;
  logic                            ready;
  logic [mpfp_pkg::ByteW-1:0]      rx_byte;
  logic                            frame_end;

  modport source (output valid, output rx_byte, output frame_end, input ready);
  modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

interface mpfp_out_if;
  logic                            valid;
  logic                            ready;
  logic [2:0]                      section;
  logic [mpfp_pkg::OffsetW-1:0]    section_offset;
  logic [mpfp_pkg::ByteW-1:0]      byte_value;
  logic                            frame_done;
  logic [2:0]                      status;

  modport source (output valid, output section, output section_offset,
                  output byte_value, output frame_done, output status, input ready);
  modport sink   (input valid, input section, input section_offset,
                  input byte_value, input frame_done, input status, output ready);
endinterface

`default_nettype wire

@@ rtl/mpfp_frame_state.sv @@
// ----------------------------------------------------------------------------
// Mesh packet frame parser frame state
// Byte counter, CRC accumulator, two-byte delay line, header field capture
// and registered section bounds.
// ----------------------------------------------------------------------------
`default_nettype none

module mpfp_frame_state (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               step_i,
  input  wire logic [mpfp_pkg::ByteW-1:0]         byte_i,
  input  wire logic                               end_i,
  input  wire logic [mpfp_pkg::CfgDataW-1:0]      magic_word_i,
  input  wire logic [mpfp_pkg::ByteW-1:0]         version_i,
  output mpfp_pkg::frame_state_t                  state_o
);

  localparam int unsigned CW = mpfp_pkg::CountW;

  localparam logic [CW-1:0] MagicHiPos = 17'd0;
  localparam logic [CW-1:0] MagicLoPos = 17'd1;
  localparam logic [CW-1:0] VersionPos = 17'd2;
  localparam logic [CW-1:0] NameLoPos  = 17'd24;
  localparam logic [CW-1:0] NameHiPos  = 17'd27;
  localparam logic [CW-1:0] PayHiPos   = 17'd28;
  localparam logic [CW-1:0] PayLoPos   = 17'd29;
  localparam logic [CW-1:0] CrcStart   = 17'd2;

  logic [CW-1:0]                    count_q, count_d;
  logic [mpfp_pkg::CrcW-1:0]        crc_q, crc_d;
  logic [mpfp_pkg::ByteW-1:0]       held0_q, held1_q;
  logic                             magic_ok_q, magic_ok_d;
  logic                             version_ok_q, version_ok_d;
  logic [mpfp_pkg::NumNames-1:0][mpfp_pkg::ByteW-1:0] len_q, len_d;
  logic [15:0]                      pay_q, pay_d;
  logic [mpfp_pkg::NumBounds-1:0][CW-1:0] bound_q, bound_d;

  always_comb begin
    magic_ok_d   = magic_ok_q;
    version_ok_d = version_ok_q;
    len_d        = len_q;
    pay_d        = pay_q;
    if (count_q == MagicHiPos) begin
      magic_ok_d = (byte_i == magic_word_i[15:8]);
    end else if (count_q == MagicLoPos) begin
      magic_ok_d = magic_ok_q && (byte_i == magic_word_i[7:0]);
    end else if (count_q == VersionPos) begin
      version_ok_d = (byte_i == version_i);
    end else if (count_q >= NameLoPos && count_q <= NameHiPos) begin
      len_d[count_q[1:0]] = byte_i;
    end else if (count_q == PayHiPos) begin
      pay_d[15:8] = byte_i;
    end else if (count_q == PayLoPos) begin
      pay_d[7:0] = byte_i;
    end

    crc_d   = (count_q >= CrcStart) ? mpfp_pkg::crc_feed(crc_q, held0_q) : crc_q;
    count_d = (count_q == mpfp_pkg::CountMax) ? count_q : count_q + 1'b1;
  end

  always_comb begin
    bound_d[0] = CW'(mpfp_pkg::HeaderBytes) + CW'(len_q[0]);
    bound_d[1] = CW'(mpfp_pkg::HeaderBytes) + (CW'(len_q[0]) + CW'(len_q[1]));
    bound_d[2] = bound_d[1] + CW'(len_q[2]);
    bound_d[3] = bound_d[1] + (CW'(len_q[2]) + CW'(len_q[3]));
    bound_d[4] = bound_d[3] + CW'(pay_q);
    bound_d[5] = bound_d[4] + CW'(2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      crc_q        <= mpfp_pkg::CrcInit;
      held0_q      <= '0;
      held1_q      <= '0;
      magic_ok_q   <= 1'b0;
      version_ok_q <= 1'b0;
      len_q        <= '0;
      pay_q        <= '0;
    end else if (step_i) begin
      if (end_i) begin
        count_q      <= '0;
        crc_q        <= mpfp_pkg::CrcInit;
        held0_q      <= '0;
        held1_q      <= '0;
        magic_ok_q   <= 1'b0;
        version_ok_q <= 1'b0;
        len_q        <= '0;
        pay_q        <= '0;
      end else begin
        count_q      <= count_d;
        crc_q        <= crc_d;
        held0_q      <= held1_q;
        held1_q      <= byte_i;
        magic_ok_q   <= magic_ok_d;
        version_ok_q <= version_ok_d;
        len_q        <= len_d;
        pay_q        <= pay_d;
      end
    end
  end

  // bounds are registered from the lengths and follow them in the next cycle; first use is several bytes later
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < mpfp_pkg::NumBounds - 1; k++) begin
        bound_q[k] <= CW'(mpfp_pkg::HeaderBytes);
      end
      bound_q[mpfp_pkg::NumBounds-1] <= CW'(mpfp_pkg::HeaderBytes + 2);
    end else begin
      bound_q <= bound_d;
    end
  end

  assign state_o.count      = count_q;
  assign state_o.crc_next   = crc_d;
  assign state_o.held1      = held1_q;
  assign state_o.magic_ok   = magic_ok_q;
  assign state_o.version_ok = version_ok_q;
  assign state_o.bound      = bound_q;

endmodule

`default_nettype wire

@@ rtl/mpfp_tagger.sv @@
// ----------------------------------------------------------------------------
// Mesh packet frame parser tagger
// Section, section offset and end-of-frame status for one byte.
// ----------------------------------------------------------------------------
`default_nettype none

module mpfp_tagger (
  input  wire mpfp_pkg::frame_state_t             state_i,
  input  wire logic [mpfp_pkg::ByteW-1:0]         byte_i,
  input  wire logic                               end_i,
  output mpfp_pkg::tag_t                          tag_o
);

  localparam int unsigned CW = mpfp_pkg::CountW;

  logic [CW-1:0] idx;
  logic [CW-1:0] start;
  logic [CW:0]   len;

  assign idx = state_i.count;
  assign len = {1'b0, idx} + 1'b1;

  always_comb begin
    start = '0;
    tag_o.section = mpfp_pkg::SecHeader;
    if (idx < CW'(mpfp_pkg::HeaderBytes)) begin
      tag_o.section = mpfp_pkg::SecHeader;
      start = '0;
    end else if (idx < state_i.bound[0]) begin
      tag_o.section = mpfp_pkg::SecSource;
      start = CW'(mpfp_pkg::HeaderBytes);
    end else if (idx < state_i.bound[1]) begin
      tag_o.section = mpfp_pkg::SecDest;
      start = state_i.bound[0];
    end else if (idx < state_i.bound[2]) begin
      tag_o.section = mpfp_pkg::SecPrevHop;
      start = state_i.bound[1];
    end else if (idx < state_i.bound[3]) begin
      tag_o.section = mpfp_pkg::SecNextHop;
      start = state_i.bound[2];
    end else if (idx < state_i.bound[4]) begin
      tag_o.section = mpfp_pkg::SecPayload;
      start = state_i.bound[3];
    end else if (idx < state_i.bound[5]) begin
      tag_o.section = mpfp_pkg::SecCrc;
      start = state_i.bound[4];
    end else begin
      tag_o.section = mpfp_pkg::SecExcess;
      start = state_i.bound[5];
    end
    tag_o.offset = mpfp_pkg::OffsetW'(idx - start);

    tag_o.status = mpfp_pkg::StatusOk;
    if (end_i) begin
      if (idx < CW'(mpfp_pkg::HeaderBytes + 1)) begin
        tag_o.status = mpfp_pkg::StatusShort;
      end else if (!state_i.magic_ok) begin
        tag_o.status = mpfp_pkg::StatusMagic;
      end else if (!state_i.version_ok) begin
        tag_o.status = mpfp_pkg::StatusVersion;
      end else if (idx == mpfp_pkg::CountMax || len != {1'b0, state_i.bound[5]}) begin
        tag_o.status = mpfp_pkg::StatusLength;
      end else if (state_i.crc_next != {state_i.held1, byte_i}) begin
        tag_o.status = mpfp_pkg::StatusCrc;
      end else begin
        tag_o.status = mpfp_pkg::StatusOk;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/mesh_packet_frame_parser.sv @@
// ----------------------------------------------------------------------------
// Mesh packet frame parser
// Tags each received frame byte with its section and offset and reports the
// frame status on the final byte.
//
// Bytes enter on in_i (rx_byte, frame_end), one transfer per cycle at most.
// Each byte gives exactly one result on out_o: section, section_offset,
// byte_value, frame_done and status (status is nonzero only with frame_done).
// An accepted byte lands in an input register; the tagger and the CRC update
// sit between that register and the result register; one byte per cycle is
// sustained while out_o.ready stays high.
// Frame state (counter, CRC, header fields) advances when a byte moves from
// the input register to the result register.
// Configuration: cfg_we_i with cfg_idx_i 0 writes magic_word, 1 writes
// protocol_version; write only while no frame byte is in flight.
// Reset clears the frame state and the valid flags of both registers; no clearing pass.
// A stalled receiver holds the result; one more byte is taken into the input
// register, then in_i.ready drops until out_o.ready returns.
// ----------------------------------------------------------------------------
`default_nettype none

`include "mesh_packet_frame_parser_macros.svh"

module mesh_packet_frame_parser (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  mpfp_in_if.sink                                 in_i,
  mpfp_out_if.source                              out_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [mpfp_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  wire logic [mpfp_pkg::CfgDataW-1:0]      cfg_wdata_i
);

  logic [mpfp_pkg::CfgDataW-1:0] magic_q;
  logic [mpfp_pkg::ByteW-1:0]    version_q;

  logic                          s1_valid_q;
  logic [mpfp_pkg::ByteW-1:0]    s1_byte_q;
  logic                          s1_end_q;
  logic                          advance;

  logic                          out_valid_q;
  mpfp_pkg::tag_t                tag;
  mpfp_pkg::tag_t                tag_q;
  logic [mpfp_pkg::ByteW-1:0]    out_byte_q;
  logic                          out_done_q;

  mpfp_pkg::frame_state_t        st;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q   <= '0;
      version_q <= '0;
    end else if (cfg_we_i) begin
      case (mpfp_pkg::cfg_idx_e'(cfg_idx_i))
        mpfp_pkg::CfgMagicWord:       magic_q   <= cfg_wdata_i;
        mpfp_pkg::CfgProtocolVersion: version_q <= cfg_wdata_i[mpfp_pkg::ByteW-1:0];
        default: ;
      endcase
    end
  end

  assign advance     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_byte_q <= in_i.rx_byte;
      s1_end_q  <= in_i.frame_end;
    end
  end

  mpfp_frame_state u_state (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .byte_i       (s1_byte_q),
    .end_i        (s1_end_q),
    .magic_word_i (magic_q),
    .version_i    (version_q),
    .state_o      (st)
  );

  mpfp_tagger u_tagger (
    .state_i (st),
    .byte_i  (s1_byte_q),
    .end_i   (s1_end_q),
    .tag_o   (tag)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      tag_q      <= tag;
      out_byte_q <= s1_byte_q;
      out_done_q <= s1_end_q;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.section        = tag_q.section;
  assign out_o.section_offset = tag_q.offset;
  assign out_o.byte_value     = out_byte_q;
  assign out_o.frame_done     = out_done_q;
  assign out_o.status         = tag_q.status;

  `MPFP_ASSERT_IMP(a_ready_stall, clk_i, rst_ni, !in_i.ready, s1_valid_q && out_valid_q && !out_o.ready)
  `MPFP_ASSERT_NXT(a_advance_fills, clk_i, rst_ni, advance, out_valid_q)
  `MPFP_ASSERT_IMP(a_status_only_done, clk_i, rst_ni, out_valid_q && !out_done_q, tag_q.status == mpfp_pkg::StatusOk)
  `MPFP_ASSERT_NXT(a_frame_clears, clk_i, rst_ni, advance && s1_end_q, st.count == '0)

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mesh packet frame parser testbench
// Sends frames byte by byte through the input channel and predicts, for
// every byte, its section, offset, pass-through value and, on the final
// byte, the frame status. Results are checked in order as they leave the
// output channel. Covers single-byte and short frames, one frame per
// status code, random well-formed frames with corrupted variants and noise,
// a long output stall, and several magic and version settings including
// both extremes.
// ----------------------------------------------------------------------------

module tb_top;
  import mpfp_pkg::*;

  localparam int          StallLimit  = 1000;
  localparam int          DrainCycles = 4;
  localparam int          ReportCap   = 100;
  localparam int          HoldCycles  = 80;
  localparam logic [15:0] CcittPoly   = 16'h1021;
  localparam logic [15:0] CcittSeed   = 16'hFFFF;

  typedef enum int {
    FrmGood,
    FrmBadCrc,
    FrmBadLen,
    FrmBadMagic,
    FrmBadVersion,
    FrmShort,
    FrmNoise
  } frame_kind_e;

  typedef struct {
    section_e    section;
    logic [15:0] offset;
    logic [7:0]  value;
    logic        done;
    status_e     status;
  } tag_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  mpfp_in_if  in_if ();
  mpfp_out_if out_if ();

  mesh_packet_frame_parser u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // parser model state
  logic [15:0]      magic_cfg   = '0;
  logic [7:0]       version_cfg = '0;
  logic [CountW-1:0] frame_count;
  logic [15:0]      crc_run;
  logic [7:0]       held_older;
  logic [7:0]       held_newer;
  logic             magic_seen;
  logic             version_seen;
  logic [7:0]       name_len [4];
  logic [15:0]      payload_len;

  tag_result_t expected_tags [$];
  logic [7:0]  frame_buf [$];

  int  errors        = 0;
  int  bytes_sent    = 0;
  int  frames_sent   = 0;
  int  settings_used = 1;
  int  quiet_cycles  = 0;
  int  sink_hold     = 0;
  bit  src_idle      = 1'b1;
  bit  sink_idle     = 1'b1;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [15:0] ccitt_update(input logic [15:0] acc, input logic [7:0] d);
    logic [15:0] r;
    r = acc ^ {d, 8'h00};
    for (int k = 0; k < 8; k++) begin
      r = r[15] ? ((r << 1) ^ CcittPoly) : (r << 1);
    end
    return r;
  endfunction

  task automatic clear_frame();
    frame_count  = '0;
    crc_run      = CcittSeed;
    held_older   = '0;
    held_newer   = '0;
    magic_seen   = 1'b0;
    version_seen = 1'b0;
    for (int k = 0; k < 4; k++) name_len[k] = '0;
    payload_len  = '0;
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic last, output tag_result_t t);
    int unsigned idx;
    int unsigned start;
    int unsigned bnd [6];
    int unsigned frame_len;
    logic [31:0] rel_pos;
    idx = frame_count;
    start = 0;
    if (idx == 0) begin
      magic_seen = (b == magic_cfg[15:8]);
    end else if (idx == 1) begin
      magic_seen = magic_seen && (b == magic_cfg[7:0]);
    end else if (idx == 2) begin
      version_seen = (b == version_cfg);
    end else if (idx >= 24 && idx <= 27) begin
      name_len[idx - 24] = b;
    end else if (idx == 28) begin
      payload_len[15:8] = b;
    end else if (idx == 29) begin
      payload_len[7:0] = b;
    end

    bnd[0] = HeaderBytes;
    for (int k = 0; k < 4; k++) bnd[k + 1] = bnd[k] + name_len[k];
    bnd[5] = bnd[4] + payload_len;
    t.section = SecHeader;
    if (idx >= HeaderBytes) begin
      if (idx < bnd[1]) begin
        t.section = SecSource;  start = bnd[0];
      end else if (idx < bnd[2]) begin
        t.section = SecDest;    start = bnd[1];
      end else if (idx < bnd[3]) begin
        t.section = SecPrevHop; start = bnd[2];
      end else if (idx < bnd[4]) begin
        t.section = SecNextHop; start = bnd[3];
      end else if (idx < bnd[5]) begin
        t.section = SecPayload; start = bnd[4];
      end else if (idx < bnd[5] + 2) begin
        t.section = SecCrc;     start = bnd[5];
      end else begin
        t.section = SecExcess;  start = bnd[5] + 2;
      end
    end
    rel_pos = idx - start;
    t.offset = rel_pos[15:0];
    t.value  = b;
    t.done   = last;
    t.status = StatusOk;

    // CRC trails the stream by two bytes
    if (idx >= 2) crc_run = ccitt_update(crc_run, held_older);

    if (last) begin
      frame_len = idx + 1;
      if (frame_len < HeaderBytes + 2) begin
        t.status = StatusShort;
      end else if (!magic_seen) begin
        t.status = StatusMagic;
      end else if (!version_seen) begin
        t.status = StatusVersion;
      end else if (idx >= CountMax || frame_len != bnd[5] + 2) begin
        t.status = StatusLength;
      end else if (crc_run != {held_newer, b}) begin
        t.status = StatusCrc;
      end
      clear_frame();
    end else begin
      held_older = held_newer;
      held_newer = b;
      if (frame_count != CountMax) frame_count++;
    end
  endtask

  task automatic report_mismatch(input string field, input int unsigned want,
                                 input int unsigned got);
    errors++;
    $error("%s: expected %0d, got %0d", field, want, got);
  endtask

  always @(posedge clk_i) begin : check_results
    tag_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_tags.size() == 0) begin
        errors++;
        if (errors <= ReportCap) $error("result with no byte pending, byte 0x%02h",
                                        out_if.byte_value);
      end else begin
        want = expected_tags.pop_front();
        if (out_if.section !== want.section)
          report_mismatch("section", want.section, out_if.section);
        if (out_if.section_offset !== want.offset)
          report_mismatch("section_offset", want.offset, out_if.section_offset);
        if (out_if.byte_value !== want.value)
          report_mismatch("byte_value", want.value, out_if.byte_value);
        if (out_if.frame_done !== want.done)
          report_mismatch("frame_done", want.done, out_if.frame_done);
        if (out_if.status !== want.status)
          report_mismatch("status", want.status, out_if.status);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles = 0;
    end else if (rst_ni) begin
      quiet_cycles++;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("mesh_packet_frame_parser regression: fail");
      $finish;
    end
  end

  // result receiver: random stall per transfer, or one long hold when asked
  initial begin : result_sink
    int gap;
    out_if.ready = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (sink_hold > 0) begin
        gap = sink_hold;
        sink_hold = 0;
      end else begin
        gap = sink_idle ? $urandom_range(0, 17) : 0;
      end
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    tag_result_t t;
    gap = src_idle ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.rx_byte   <= b;
    in_if.frame_end <= last;
    do @(posedge clk_i); while (!in_if.ready);
    predict_byte(b, last, t);
    expected_tags = {expected_tags, t};
    bytes_sent++;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (expected_tags.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgMagicWord) magic_cfg = data;
    else version_cfg = data[7:0];
    @(posedge clk_i);
  endtask

  // upper data bits of the version write are junk; the register keeps 8 bits
  task automatic set_registers(input logic [15:0] magic, input logic [7:0] ver);
    cfg_write(CfgMagicWord, magic);
    cfg_write(CfgProtocolVersion, {8'($urandom_range(0, 255)), ver});
    settings_used++;
  endtask

  task automatic add_byte(input logic [7:0] b);
    frame_buf = {frame_buf, b};
  endtask

  task automatic build_header(input logic [15:0] magic, input logic [7:0] ver,
                              input logic [3:0][7:0] names, input logic [15:0] pay);
    frame_buf.delete();
    repeat (HeaderBytes) add_byte(8'($urandom_range(0, 255)));
    frame_buf[0] = magic[15:8];
    frame_buf[1] = magic[7:0];
    frame_buf[2] = ver;
    for (int k = 0; k < 4; k++) frame_buf[24 + k] = names[k];
    frame_buf[28] = pay[15:8];
    frame_buf[29] = pay[7:0];
  endtask

  task automatic build_frame(input frame_kind_e kind, input bit big);
    logic [3:0][7:0] names;
    logic [15:0]     pay;
    logic [15:0]     magic;
    logic [7:0]      ver;
    logic [15:0]     crc;
    int              n;
    int              k;
    frame_buf.delete();
    case (kind)
      FrmShort, FrmNoise: begin
        n = (kind == FrmShort) ? $urandom_range(1, HeaderBytes + 1) : $urandom_range(1, 120);
        repeat (n) add_byte(8'($urandom_range(0, 255)));
        if (kind == FrmShort && n >= 3 && $urandom_range(0, 1) == 1) begin
          frame_buf[0] = magic_cfg[15:8];
          frame_buf[1] = magic_cfg[7:0];
          frame_buf[2] = version_cfg;
        end
      end
      default: begin
        for (k = 0; k < 4; k++) begin
          names[k] = big ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 5));
        end
        pay   = big ? 16'($urandom_range(0, 700)) : 16'($urandom_range(0, 24));
        magic = magic_cfg;
        ver   = version_cfg;
        if (kind == FrmBadMagic) magic ^= 16'h0001 << $urandom_range(0, 15);
        if (kind == FrmBadVersion) ver ^= 8'h01 << $urandom_range(0, 7);
        build_header(magic, ver, names, pay);
        n = int'(names[0]) + int'(names[1]) + int'(names[2]) + int'(names[3]) + int'(pay);
        repeat (n) add_byte(8'($urandom_range(0, 255)));
        crc = CcittSeed;
        foreach (frame_buf[i]) crc = ccitt_update(crc, frame_buf[i]);
        add_byte(crc[15:8]);
        add_byte(crc[7:0]);
        if (kind == FrmBadCrc) begin
          k = frame_buf.size() - 1 - $urandom_range(0, 1);
          frame_buf[k] ^= 8'h01 << $urandom_range(0, 7);
        end
        if (kind == FrmBadLen) begin
          if ($urandom_range(0, 1) == 1) begin
            repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)));
          end else begin
            frame_buf[28] = 8'($urandom_range(0, 255));
            frame_buf[29] = 8'($urandom_range(0, 255));
          end
        end
      end
    endcase
  endtask

  task automatic send_frame();
    foreach (frame_buf[i]) send_byte(frame_buf[i], i == frame_buf.size() - 1);
    frames_sent++;
  endtask

  task automatic random_frame();
    int          roll;
    frame_kind_e kind;
    roll = $urandom_range(0, 99);
    if (roll < 50)      kind = FrmGood;
    else if (roll < 60) kind = FrmBadCrc;
    else if (roll < 72) kind = FrmBadLen;
    else if (roll < 79) kind = FrmBadMagic;
    else if (roll < 86) kind = FrmBadVersion;
    else if (roll < 93) kind = FrmShort;
    else                kind = FrmNoise;
    src_idle  = ($urandom_range(0, 3) != 0);
    sink_idle = ($urandom_range(0, 3) != 0);
    build_frame(kind, $urandom_range(0, 39) == 0);
    send_frame();
  endtask

  task automatic test_single_bytes();
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b1);
    for (int k = 0; k < 20; k++) send_byte((k % 2 == 0) ? 8'hFF : 8'h00, k == 19);
    frames_sent += 4;
    drain();
  endtask

  task automatic test_status_codes();
    frame_kind_e order [6] = '{FrmGood, FrmShort, FrmBadMagic, FrmBadVersion,
                               FrmBadLen, FrmBadCrc};
    foreach (order[k]) begin
      build_frame(order[k], 1'b0);
      send_frame();
    end
    drain();
  endtask

  task automatic test_backpressure();
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    sink_hold = HoldCycles;
    repeat (2) begin
      build_frame(FrmGood, 1'b0);
      send_frame();
    end
    drain();
  endtask

  task automatic test_random_frames(input int amount);
    int stop_at;
    stop_at = bytes_sent + amount;
    while (bytes_sent < stop_at) random_frame();
    drain();
  endtask

  initial begin
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.rx_byte   = '0;
    in_if.frame_end = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CfgMagicWord;
    cfg_wdata_i     = '0;
    clear_frame();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_bytes();
    test_status_codes();
    test_backpressure();
    test_random_frames(250);
    set_registers(16'hFFFF, 8'hFF);
    test_random_frames(250);
    set_registers(16'h0000, 8'h00);
    test_random_frames(250);
    set_registers(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
    test_random_frames(250);
    set_registers(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
    test_random_frames(250);

    if (expected_tags.size() != 0) begin
      errors++;
      $error("%0d expected results never arrived", expected_tags.size());
    end
    $display("summary: %0d bytes in %0d frames under %0d register settings",
             bytes_sent, frames_sent, settings_used);
    $display("summary: every status code, noise frames and a long output stall");
    if (errors == 0) begin
      $display("mesh_packet_frame_parser regression: pass");
    end else begin
      $display("mesh_packet_frame_parser regression: fail");
    end
    $finish;
  end

endmodule
